// ===== src/lrupr_pkg.sv =====
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared types and fixed widths for the lru page replacement block.
// ----------------------------------------------------------------------------
package lrupr_pkg;

  localparam int FRAME_W = 3;   // width of the reported frame index
  localparam int CFG_W   = 4;   // width of the frame count register write
  localparam int COUNT_W = 32;  // width of the hit and fault totals

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_AGE  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  // frame store commands; clear acts on every frame, the others at the addressed frame
  typedef struct packed {
    logic clear;    // drop every page, ranks back to frame index
    logic load;     // write new page and mark valid
    logic set_mru;  // rank goes to zero
    logic bump;     // rank ages by one
  } store_cmd_t;

endpackage

// ===== src/lru_page_replacement.sv =====
// ----------------------------------------------------------------------------
// lru_page_replacement
// Least recently used page replacement over a small set of frames.
// ----------------------------------------------------------------------------
// One page reference is taken at a time. A single compare unit walks the
// frames in use twice, one frame per cycle: first to find a match and the
// oldest frame, then to age the ranks and, on a fault, install the page.
// The result is presented through an output register, so a stalled result
// holds up only the final step of the next request. Writing the frame
// count (clamped to 1..MAX_FRAMES) empties all frames and zeroes the hit
// and fault totals.
module lru_page_replacement #(
  parameter int MAX_FRAMES = 8,
  parameter int PAGE_BITS  = 16
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  // request: page
  input  logic                                        in_tvalid,
  output logic                                        in_tready,
  input  logic [((PAGE_BITS + 7) / 8) * 8-1:0]        in_tdata,
  // result: hit, frame, evicted_valid, evicted_page, fault_total, hit_total
  output logic                                        out_tvalid,
  input  logic                                        out_tready,
  output logic [((PAGE_BITS + 69 + 7) / 8) * 8-1:0]   out_tdata,
  // frame count register
  input  logic                                        cfg_valid,
  output logic                                        cfg_ready,
  input  logic [lrupr_pkg::CFG_W-1:0]                 cfg_data
);

  localparam int IW       = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CW       = $clog2(MAX_FRAMES + 1);
  localparam int FRAME_W  = lrupr_pkg::FRAME_W;
  localparam int COUNT_W  = lrupr_pkg::COUNT_W;
  localparam int OUT_W    = ((PAGE_BITS + 69 + 7) / 8) * 8;
  localparam int RST_FRAMES = (MAX_FRAMES < 8) ? MAX_FRAMES : 8;

  lrupr_pkg::state_t     state_r, state_nxt;
  lrupr_pkg::store_cmd_t cmd;

  logic [CW-1:0]        n_r, n_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [PAGE_BITS-1:0] page_r, page_nxt;
  logic                 found_r, found_nxt;
  logic [IW-1:0]        match_idx_r, match_idx_nxt;
  logic [IW-1:0]        match_rank_r, match_rank_nxt;
  logic [IW-1:0]        victim_r, victim_nxt;
  logic [IW-1:0]        max_rank_r, max_rank_nxt;
  logic                 ev_valid_r, ev_valid_nxt;
  logic [PAGE_BITS-1:0] ev_page_r, ev_page_nxt;
  logic [COUNT_W-1:0]   fault_r, fault_nxt;
  logic [COUNT_W-1:0]   hit_r, hit_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]     out_data_r, out_data_nxt;

  logic [IW-1:0]        idx;
  logic [PAGE_BITS-1:0] rd_page;
  logic                 rd_valid;
  logic [IW-1:0]        rd_rank;
  logic [IW-1:0]        sel;
  logic [IW-1:0]        old_rank;
  logic                 last;
  logic                 in_fire;
  logic                 cfg_fire;
  logic                 done_fire;
  logic [COUNT_W-1:0]   fault_inc;
  logic [COUNT_W-1:0]   hit_inc;
  int unsigned          cfg_clamped;

  assign idx       = cnt_r[IW-1:0];
  assign last      = (cnt_r == (n_r - CW'(1)));
  assign sel       = found_r ? match_idx_r : victim_r;
  assign old_rank  = found_r ? match_rank_r : max_rank_r;

  assign in_tready = (state_r == lrupr_pkg::ST_IDLE);
  assign cfg_ready = (state_r == lrupr_pkg::ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign done_fire = (state_r == lrupr_pkg::ST_DONE) && (!out_valid_r || out_tready);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // saturating totals
  assign fault_inc = (fault_r == '1) ? fault_r : fault_r + COUNT_W'(1);
  assign hit_inc   = (hit_r == '1) ? hit_r : hit_r + COUNT_W'(1);

  always_comb begin
    cfg_clamped = 32'(cfg_data);
    if (cfg_clamped < 1) begin
      cfg_clamped = 1;
    end
    if (cfg_clamped > MAX_FRAMES) begin
      cfg_clamped = MAX_FRAMES;
    end
  end

  lrupr_store #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .idx      (idx),
    .new_page (page_r),
    .rd_page  (rd_page),
    .rd_valid (rd_valid),
    .rd_rank  (rd_rank)
  );

  always_comb begin
    state_nxt      = state_r;
    n_nxt          = n_r;
    cnt_nxt        = cnt_r;
    page_nxt       = page_r;
    found_nxt      = found_r;
    match_idx_nxt  = match_idx_r;
    match_rank_nxt = match_rank_r;
    victim_nxt     = victim_r;
    max_rank_nxt   = max_rank_r;
    ev_valid_nxt   = ev_valid_r;
    ev_page_nxt    = ev_page_r;
    fault_nxt      = fault_r;
    hit_nxt        = hit_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    cmd            = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      lrupr_pkg::ST_IDLE: begin
        if (cfg_fire) begin
          n_nxt     = CW'(cfg_clamped);
          fault_nxt = '0;
          hit_nxt   = '0;
          cmd.clear = 1'b1;
        end
        if (in_fire) begin
          page_nxt  = in_tdata[PAGE_BITS-1:0];
          found_nxt = 1'b0;
          cnt_nxt   = '0;
          state_nxt = lrupr_pkg::ST_SCAN;
        end
      end
      lrupr_pkg::ST_SCAN: begin
        // first valid match wins
        if (rd_valid && (rd_page == page_r) && !found_r) begin
          found_nxt      = 1'b1;
          match_idx_nxt  = idx;
          match_rank_nxt = rd_rank;
        end
        // oldest frame, lowest index on ties
        if ((cnt_r == '0) || (rd_rank > max_rank_r)) begin
          victim_nxt   = idx;
          max_rank_nxt = rd_rank;
          ev_valid_nxt = rd_valid;
          ev_page_nxt  = rd_page;
        end
        if (last) begin
          cnt_nxt   = '0;
          state_nxt = lrupr_pkg::ST_AGE;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      lrupr_pkg::ST_AGE: begin
        if (idx == sel) begin
          cmd.set_mru = 1'b1;
          cmd.load    = !found_r;
        end else if (rd_rank < old_rank) begin
          cmd.bump = 1'b1;
        end
        if (last) begin
          cnt_nxt   = '0;
          state_nxt = lrupr_pkg::ST_DONE;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      lrupr_pkg::ST_DONE: begin
        if (done_fire) begin
          if (found_r) begin
            hit_nxt = hit_inc;
          end else begin
            fault_nxt = fault_inc;
          end
          out_data_nxt                          = '0;
          out_data_nxt[0]                       = found_r;
          out_data_nxt[3:1]                     = FRAME_W'(sel);
          out_data_nxt[4]                       = !found_r && ev_valid_r;
          out_data_nxt[5 +: PAGE_BITS]          = (!found_r && ev_valid_r) ? ev_page_r : '0;
          out_data_nxt[5 + PAGE_BITS +: COUNT_W] = found_r ? fault_r : fault_inc;
          out_data_nxt[37 + PAGE_BITS +: COUNT_W] = found_r ? hit_inc : hit_r;
          out_valid_nxt                         = 1'b1;
          state_nxt                             = lrupr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lrupr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lrupr_pkg::ST_IDLE;
      n_r         <= CW'(RST_FRAMES);
      cnt_r       <= '0;
      found_r     <= 1'b0;
      fault_r     <= '0;
      hit_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      cnt_r       <= cnt_nxt;
      found_r     <= found_nxt;
      fault_r     <= fault_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r       <= page_nxt;
    match_idx_r  <= match_idx_nxt;
    match_rank_r <= match_rank_nxt;
    victim_r     <= victim_nxt;
    max_rank_r   <= max_rank_nxt;
    ev_valid_r   <= ev_valid_nxt;
    ev_page_r    <= ev_page_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule

// ===== src/lrupr_store.sv =====
// ----------------------------------------------------------------------------
// lrupr_store
// Frame store: page, valid bit and recency rank per frame, one access port.
// ----------------------------------------------------------------------------
module lrupr_store #(
  parameter int MAX_FRAMES = 8,
  parameter int PAGE_BITS  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  lrupr_pkg::store_cmd_t                  cmd,
  input  logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] idx,
  input  logic [PAGE_BITS-1:0]                   new_page,
  output logic [PAGE_BITS-1:0]                   rd_page,
  output logic                                   rd_valid,
  output logic [((MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1)-1:0] rd_rank
);

  localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

  logic [PAGE_BITS-1:0] page_r  [MAX_FRAMES];
  logic                 valid_r [MAX_FRAMES];
  logic [IW-1:0]        rank_r  [MAX_FRAMES];

  assign rd_page  = page_r[idx];
  assign rd_valid = valid_r[idx];
  assign rd_rank  = rank_r[idx];

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
        valid_r[i] <= 1'b0;
        rank_r[i]  <= IW'(i);
      end
    end else begin
      if (cmd.set_mru) begin
        rank_r[idx] <= '0;
      end else if (cmd.bump) begin
        rank_r[idx] <= rank_r[idx] + IW'(1);
      end
      if (cmd.load) begin
        valid_r[idx] <= 1'b1;
      end
    end
  end

  // page contents only matter behind a valid bit
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page_r[idx] <= new_page;
    end
  end

endmodule
